// ----- hdl/ipcd_pkg.sv -----
// Types and constants shared by the image pair compare and diff block.
package ipcd_pkg;

    // Diff pixel colors and the fixed red limit
    localparam logic [7:0] RED_LIMIT      = 8'd25;
    localparam logic [7:0] MARK_RED       = 8'd255;
    localparam logic [7:0] MARK_GREEN_BLUE = 8'd40;
    localparam logic [7:0] GRAY_MAX       = 8'd102;

    // Reset value of the change threshold register
    localparam logic [7:0] THRESH_RESET = 8'd25;

    // Frame length beyond which pixels no longer reach the totals
    localparam logic [24:0] MAX_PIXELS = 25'd16777216;

    // Luminance weights, scaled by 1000
    localparam logic [17:0] LUM_WR = 18'd299;
    localparam logic [17:0] LUM_WG = 18'd587;
    localparam logic [17:0] LUM_WB = 18'd114;

    // floor(s / 1000) = (s * LUM_RECIP) >> LUM_SHIFT, exact for s below 493000
    localparam logic [36:0] LUM_RECIP = 37'd268436;
    localparam int          LUM_SHIFT = 28;

    // floor(lum * 4 / 10) = (lum * GRAY_MUL) >> GRAY_SHIFT for lum below 512
    localparam logic [16:0] GRAY_MUL   = 17'd205;
    localparam int          GRAY_SHIFT = 9;

    typedef struct packed {
        logic [7:0] a_red;
        logic [7:0] a_green;
        logic [7:0] a_blue;
        logic [7:0] a_alpha;
        logic [7:0] b_red;
        logic [7:0] b_green;
        logic [7:0] b_blue;
        logic [7:0] b_alpha;
        logic       last_pixel;
    } pixel_pair_t;

    typedef struct packed {
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic [33:0] abs_diff_total;
        logic [24:0] changed_total;
        logic [24:0] pixel_total;
        logic        all_identical;
        logic        frame_done;
    } diff_result_t;

    // Frame totals as they travel down the pipeline with their pixel
    typedef struct packed {
        logic [33:0] abs_diff_total;
        logic [24:0] changed_total;
        logic [24:0] pixel_total;
        logic        all_identical;
        logic        frame_done;
    } frame_totals_t;

endpackage

// ----- hdl/image_pair_compare_diff.sv -----
// Image pair compare: diff pixel per RGBA pair plus per-frame difference totals.
//
//   channel  direction  payload          accepted when
//   -------  ---------  ---------------  -------------------------
//   in       sink       pixel_pair_t     in_valid && in_ready
//   out      source     diff_result_t    out_valid && out_ready
//   cfg      sink       change threshold cfg_valid && cfg_ready
//
// One item per cycle sustained while out_ready is high; an accepted item goes from the input
// register through weighted sum and accumulate, reciprocal multiply and the output register.
// The reciprocal multiply for the divide by 1000 sets the depth of the pipeline.
// The pipeline stalls as a whole only when a full output register is not taken;
// empty stages keep filling, so input is taken while a result waits.
// rst_n clears all valid flags and the frame accumulators, and sets the threshold to 25.
// cfg_ready is always high; the threshold is sampled when a pixel leaves the input register.
module image_pair_compare_diff (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ipcd_pkg::pixel_pair_t in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ipcd_pkg::diff_result_t out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_data
);
    import ipcd_pkg::*;

    // Configuration
    logic [7:0] threshold_reg;

    // Stage enables: a stage loads when it is empty or its content moves on
    logic en_s1;
    logic en_s2;
    logic en_s3;
    logic en_out;

    // Stage 1: input register
    logic        s1_valid_reg;
    pixel_pair_t s1_data_reg;

    // Stage 2: weighted sum, red decision, totals
    logic          s2_valid_reg;
    logic [17:0]   s2_lum_sum_reg;
    logic          s2_red_reg;
    frame_totals_t s2_totals_reg;

    // Stage 3: luminance
    logic          s3_valid_reg;
    logic [7:0]    s3_lum_reg;
    logic          s3_red_reg;
    frame_totals_t s3_totals_reg;

    // Output register
    logic         out_valid_reg;
    diff_result_t out_data_reg;

    // Frame accumulators
    logic [33:0] diff_sum_acc_reg;
    logic [33:0] diff_sum_acc_next;
    logic [24:0] changed_acc_reg;
    logic [24:0] changed_acc_next;
    logic [24:0] pixel_acc_reg;
    logic [24:0] pixel_acc_next;
    logic        equal_so_far_reg;
    logic        equal_so_far_next;

    // Stage 1 combinational work
    logic [7:0]    diff_r;
    logic [7:0]    diff_g;
    logic [7:0]    diff_b;
    logic [7:0]    diff_max;
    logic [9:0]    diff_rgb;
    logic          mismatch;
    logic          in_range;
    logic [17:0]   lum_sum;
    logic [33:0]   diff_sum;
    logic [24:0]   changed_sum;
    logic [24:0]   pixel_sum;
    logic          equal_now;
    frame_totals_t totals;

    // Stage 2 and 3 arithmetic
    logic [36:0] lum_prod;
    logic [16:0] gray_prod;
    logic [7:0]  gray;

    assign en_out   = !out_valid_reg || out_ready;
    assign en_s3    = !s3_valid_reg || en_out;
    assign en_s2    = !s2_valid_reg || en_s3;
    assign en_s1    = !s1_valid_reg || en_s2;
    assign in_ready = en_s1;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        diff_r = (s1_data_reg.a_red > s1_data_reg.b_red)
            ? s1_data_reg.a_red - s1_data_reg.b_red
            : s1_data_reg.b_red - s1_data_reg.a_red;
        diff_g = (s1_data_reg.a_green > s1_data_reg.b_green)
            ? s1_data_reg.a_green - s1_data_reg.b_green
            : s1_data_reg.b_green - s1_data_reg.a_green;
        diff_b = (s1_data_reg.a_blue > s1_data_reg.b_blue)
            ? s1_data_reg.a_blue - s1_data_reg.b_blue
            : s1_data_reg.b_blue - s1_data_reg.a_blue;

        diff_max = (diff_r > diff_g) ? diff_r : diff_g;
        diff_max = (diff_max > diff_b) ? diff_max : diff_b;
        diff_rgb = 10'(diff_r) + 10'(diff_g) + 10'(diff_b);

        mismatch = (diff_rgb != 10'd0) || (s1_data_reg.a_alpha != s1_data_reg.b_alpha);

        lum_sum = LUM_WR * 18'(s1_data_reg.a_red)
                + LUM_WG * 18'(s1_data_reg.a_green)
                + LUM_WB * 18'(s1_data_reg.a_blue);

        // Pixels past the frame limit still get a diff pixel but touch no total
        in_range    = pixel_acc_reg < MAX_PIXELS;
        pixel_sum   = pixel_acc_reg + 25'(in_range);
        diff_sum    = diff_sum_acc_reg + (in_range ? 34'(diff_rgb) : 34'd0);
        changed_sum = changed_acc_reg + 25'(in_range && (diff_max > threshold_reg));
        equal_now   = equal_so_far_reg && !(in_range && mismatch);

        if (s1_data_reg.last_pixel)
        begin
            totals.abs_diff_total = diff_sum;
            totals.changed_total  = changed_sum;
            totals.pixel_total    = pixel_sum;
            totals.all_identical  = equal_now;
            totals.frame_done     = 1'b1;
            diff_sum_acc_next     = 34'd0;
            changed_acc_next      = 25'd0;
            pixel_acc_next        = 25'd0;
            equal_so_far_next     = 1'b1;
        end
        else
        begin
            totals            = '0;
            diff_sum_acc_next = diff_sum;
            changed_acc_next  = changed_sum;
            pixel_acc_next    = pixel_sum;
            equal_so_far_next = equal_now;
        end
    end

    // Divide by 1000 through the reciprocal, then scale to 40 percent
    assign lum_prod  = 37'(s2_lum_sum_reg) * LUM_RECIP;
    assign gray_prod = 17'(s3_lum_reg) * GRAY_MUL;
    assign gray      = gray_prod[GRAY_SHIFT +: 8];

    // Control state: valid flags, accumulators, threshold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESH_RESET;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            diff_sum_acc_reg <= 34'd0;
            changed_acc_reg  <= 25'd0;
            pixel_acc_reg    <= 25'd0;
            equal_so_far_reg <= 1'b1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                threshold_reg <= cfg_data;
            end
            if (en_s1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en_s2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en_s3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
            // Advance the frame state when a pixel leaves the input register
            if (en_s2 && s1_valid_reg)
            begin
                diff_sum_acc_reg <= diff_sum_acc_next;
                changed_acc_reg  <= changed_acc_next;
                pixel_acc_reg    <= pixel_acc_next;
                equal_so_far_reg <= equal_so_far_next;
            end
        end
    end

    // Payload registers: hold while stalled, no reset needed
    always_ff @(posedge clk)
    begin
        if (en_s1)
        begin
            s1_data_reg <= in_data;
        end
        if (en_s2)
        begin
            s2_lum_sum_reg <= lum_sum;
            s2_red_reg     <= diff_max > RED_LIMIT;
            s2_totals_reg  <= totals;
        end
        if (en_s3)
        begin
            s3_lum_reg    <= lum_prod[LUM_SHIFT +: 8];
            s3_red_reg    <= s2_red_reg;
            s3_totals_reg <= s2_totals_reg;
        end
        if (en_out)
        begin
            out_data_reg.out_red        <= s3_red_reg ? MARK_RED : gray;
            out_data_reg.out_green      <= s3_red_reg ? MARK_GREEN_BLUE : gray;
            out_data_reg.out_blue       <= s3_red_reg ? MARK_GREEN_BLUE : gray;
            out_data_reg.abs_diff_total <= s3_totals_reg.abs_diff_total;
            out_data_reg.changed_total  <= s3_totals_reg.changed_total;
            out_data_reg.pixel_total    <= s3_totals_reg.pixel_total;
            out_data_reg.all_identical  <= s3_totals_reg.all_identical;
            out_data_reg.frame_done     <= s3_totals_reg.frame_done;
        end
    end

endmodule

// ----- hdl/ipcd_checker.sv -----
// Port-level checks for the image pair compare block, bound to its top level.
module ipcd_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input ipcd_pkg::diff_result_t out_data
);
    import ipcd_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // Totals are zero except on the frame's last pixel
    a_totals_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.frame_done |->
            out_data.abs_diff_total == 34'd0 && out_data.changed_total == 25'd0
            && out_data.pixel_total == 25'd0 && !out_data.all_identical)
        else $error("totals nonzero away from frame end");

    // Changed count never exceeds the pixel count, which stays within the limit
    a_counts_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_done |->
            out_data.changed_total <= out_data.pixel_total
            && out_data.pixel_total <= MAX_PIXELS)
        else $error("frame counts out of bounds");

    // An identical frame has no difference at all
    a_identical: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_done && out_data.all_identical |->
            out_data.abs_diff_total == 34'd0 && out_data.changed_total == 25'd0)
        else $error("identical frame reports differences");

    // A pixel that is not the red mark is an equal-channel gray
    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_red != MARK_RED |->
            out_data.out_green == out_data.out_red && out_data.out_blue == out_data.out_red
            && out_data.out_red <= GRAY_MAX)
        else $error("malformed gray diff pixel");

endmodule

bind image_pair_compare_diff ipcd_checker u_ipcd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
